// File: rtl/clnw_pkg.sv
package clnw_pkg;

	// Request operation codes
	typedef enum logic [2:0] {
		OP_INIT   = 3'd0,
		OP_CMD    = 3'd1,
		OP_DATA   = 3'd2,
		OP_CURSOR = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	// Nibble source of one control word
	typedef enum logic [1:0] {
		NIB_CONST = 2'd0,
		NIB_HI    = 2'd1,
		NIB_LO    = 2'd2
	} nib_sel_t;

	localparam int unsigned PC_W   = 4;
	localparam int unsigned LOOP_W = 2;

	// Program entry points
	localparam logic [PC_W-1:0] ENTRY_INIT  = 4'd0;
	localparam logic [PC_W-1:0] ENTRY_CLEAR = 4'd8;
	localparam logic [PC_W-1:0] ENTRY_BYTE  = 4'd12;

	// Wakeup nibble repeats three times: loop count of the last pass
	localparam logic [LOOP_W-1:0] LOOP_LAST = 2'd2;

	localparam logic [7:0] INIT_CMD   = 8'h0F;
	localparam logic [7:0] CLEAR_CMD  = 8'h01;
	localparam logic [7:0] ROW0_BASE  = 8'h80;
	localparam logic [7:0] ROW1_BASE  = 8'hC0;
	localparam logic [3:0] DATA_HOLD  = 4'd5;

	// One microcode word
	typedef struct packed {
		nib_sel_t        nib_sel;
		logic [3:0]      const_nib;
		logic            enable;
		logic [3:0]      hold;
		logic            hold_rs;   // first data step holds longer
		logic            last;
		logic            jmp;       // jump to target while loop not done
		logic [PC_W-1:0] target;
		logic            ld_clear;  // reload byte with clear command
	} ucode_t;

	// Start of a run, from dispatch to sequencer and datapath
	typedef struct packed {
		logic            go;
		logic [PC_W-1:0] entry;
		logic [7:0]      byte_v;
		logic            rs;
	} start_t;

	// Microcode program
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		case (pc)
			4'd0:  w = '{NIB_CONST, 4'd3, 1'b1, 4'd10, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd1:  w = '{NIB_CONST, 4'd3, 1'b0, 4'd0,  1'b0, 1'b0, 1'b1, 4'd0, 1'b0};
			4'd2:  w = '{NIB_CONST, 4'd2, 1'b1, 4'd10, 1'b0, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd3:  w = '{NIB_CONST, 4'd2, 1'b0, 4'd0,  1'b0, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd4:  w = '{NIB_HI,    4'd0, 1'b1, 4'd1,  1'b0, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd5:  w = '{NIB_HI,    4'd0, 1'b0, 4'd1,  1'b0, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd6:  w = '{NIB_LO,    4'd0, 1'b1, 4'd5,  1'b0, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd7:  w = '{NIB_LO,    4'd0, 1'b0, 4'd1,  1'b0, 1'b0, 1'b0, 4'd0, 1'b1};
			4'd8:  w = '{NIB_HI,    4'd0, 1'b1, 4'd1,  1'b0, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd9:  w = '{NIB_HI,    4'd0, 1'b0, 4'd1,  1'b0, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd10: w = '{NIB_LO,    4'd0, 1'b1, 4'd5,  1'b0, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd11: w = '{NIB_LO,    4'd0, 1'b0, 4'd11, 1'b0, 1'b1, 1'b0, 4'd0, 1'b0};
			4'd12: w = '{NIB_HI,    4'd0, 1'b1, 4'd1,  1'b1, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd13: w = '{NIB_HI,    4'd0, 1'b0, 4'd1,  1'b0, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd14: w = '{NIB_LO,    4'd0, 1'b1, 4'd5,  1'b0, 1'b0, 1'b0, 4'd0, 1'b0};
			4'd15: w = '{NIB_LO,    4'd0, 1'b0, 4'd1,  1'b0, 1'b1, 1'b0, 4'd0, 1'b0};
			default: w = '{NIB_CONST, 4'd0, 1'b0, 4'd0, 1'b0, 1'b1, 1'b0, 4'd0, 1'b0};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/clnw_if.sv
// Request channel
interface clnw_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [7:0] byte_value;
	logic       row;
	logic [7:0] column;

	modport source (output valid, operation, byte_value, row, column, input ready);
	modport sink   (input valid, operation, byte_value, row, column, output ready);
endinterface

// Pin step channel
interface clnw_step_if;
	logic       valid;
	logic       ready;
	logic [3:0] nibble;
	logic       reg_select;
	logic       enable;
	logic [3:0] hold_units;
	logic       last;

	modport source (output valid, nibble, reg_select, enable, hold_units, last, input ready);
	modport sink   (input valid, nibble, reg_select, enable, hold_units, last, output ready);
endinterface

// File: rtl/clnw_seq.sv
module clnw_seq (
	input  logic                    clk,
	input  logic                    arst_n,
	input  clnw_pkg::start_t        start,
	input  logic                    slot_free,
	output logic                    busy,
	output logic                    issue,
	output clnw_pkg::ucode_t        word
);

	logic [clnw_pkg::PC_W-1:0]   pc_q;
	logic [clnw_pkg::LOOP_W-1:0] loop_q;
	logic                        busy_q;
	logic                        take_jmp;

	// Control word fetch and step decision
	always_comb begin
		word     = clnw_pkg::ucode_rom(pc_q);
		issue    = busy_q && slot_free;
		take_jmp = word.jmp && (loop_q != clnw_pkg::LOOP_LAST);
	end

	assign busy = busy_q;

	// Step counter, loop counter and run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			loop_q <= '0;
			busy_q <= 1'b0;
		end else if (start.go) begin
			pc_q   <= start.entry;
			loop_q <= '0;
			busy_q <= 1'b1;
		end else if (issue) begin
			if (word.last)
				busy_q <= 1'b0;
			if (take_jmp) begin
				pc_q   <= word.target;
				loop_q <= clnw_pkg::LOOP_W'(loop_q + 1'b1);
			end else begin
				pc_q <= clnw_pkg::PC_W'(pc_q + 1'b1);
			end
		end
	end

	// Checks
	a_loop_bound: assert property (@(posedge clk) disable iff (!arst_n)
		loop_q != 2'd3)
		else $error("wakeup loop count overran");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		issue && word.last |=> !busy_q)
		else $error("run did not end after final step");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start.go |-> !busy_q)
		else $error("run started while busy");
	a_jmp_loops: assert property (@(posedge clk) disable iff (!arst_n)
		issue && take_jmp |=> busy_q && pc_q == $past(word.target))
		else $error("loop jump missed its target");

endmodule

// File: rtl/clnw_dp.sv
module clnw_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  clnw_pkg::start_t   start,
	input  logic               issue,
	input  clnw_pkg::ucode_t   word,
	output logic               slot_free,
	clnw_step_if.source        step
);

	logic [7:0] byte_q;
	logic       rs_q;
	logic       valid_q;
	logic [3:0] nibble_q;
	logic       reg_select_q;
	logic       enable_q;
	logic [3:0] hold_q;
	logic       last_q;
	logic [3:0] nib_d;
	logic [3:0] hold_d;

	// Step fields from the control word
	always_comb begin
		case (word.nib_sel)
			clnw_pkg::NIB_HI:    nib_d = byte_q[7:4];
			clnw_pkg::NIB_LO:    nib_d = byte_q[3:0];
			clnw_pkg::NIB_CONST: nib_d = word.const_nib;
			default:             nib_d = word.const_nib;
		endcase
		hold_d = (word.hold_rs && rs_q) ? clnw_pkg::DATA_HOLD : word.hold;
	end

	// Operand byte and register select
	always_ff @(posedge clk) begin
		if (start.go) begin
			byte_q <= start.byte_v;
			rs_q   <= start.rs;
		end else if (issue && word.ld_clear) begin
			byte_q <= clnw_pkg::CLEAR_CMD;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (issue)
			valid_q <= 1'b1;
		else if (step.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			nibble_q     <= nib_d;
			reg_select_q <= rs_q;
			enable_q     <= word.enable;
			hold_q       <= hold_d;
			last_q       <= word.last;
		end
	end

	assign slot_free       = !valid_q || step.ready;
	assign step.valid      = valid_q;
	assign step.nibble     = nibble_q;
	assign step.reg_select = reg_select_q;
	assign step.enable     = enable_q;
	assign step.hold_units = hold_q;
	assign step.last       = last_q;

endmodule

// File: rtl/char_lcd_nibble_write_sequencer.sv
// An accepted request loads the step counter, then its first step is registered.
// Throughput: one pin step per cycle from the microcode step counter, 4 steps for
// command, data, cursor and clear, 16 for init; a stalled output holds the counter.
// A new request is taken the cycle after the final step enters the output register.
// Reset (arst_n low) stops any run and empties the output register.
module char_lcd_nibble_write_sequencer (
	input  logic         clk,
	input  logic         arst_n,
	clnw_req_if.sink     req,
	clnw_step_if.source  step
);

	clnw_pkg::start_t start;
	clnw_pkg::ucode_t word;
	logic             busy;
	logic             issue;
	logic             slot_free;
	logic [7:0]       cursor_cmd;

	assign req.ready  = !busy;
	assign cursor_cmd = 8'((req.row ? clnw_pkg::ROW1_BASE : clnw_pkg::ROW0_BASE)
		+ {4'd0, req.column[3:0]});

	// Dispatch: pick the program entry, operand byte and register select
	always_comb begin
		start.go     = 1'b0;
		start.entry  = clnw_pkg::ENTRY_BYTE;
		start.byte_v = req.byte_value;
		start.rs     = 1'b0;
		case (clnw_pkg::op_t'(req.operation))
			clnw_pkg::OP_INIT: begin
				start.go     = req.valid && !busy;
				start.entry  = clnw_pkg::ENTRY_INIT;
				start.byte_v = clnw_pkg::INIT_CMD;
			end
			clnw_pkg::OP_CMD: begin
				start.go = req.valid && !busy;
			end
			clnw_pkg::OP_DATA: begin
				start.go = req.valid && !busy;
				start.rs = 1'b1;
			end
			clnw_pkg::OP_CURSOR: begin
				start.go     = req.valid && !busy;
				start.byte_v = cursor_cmd;
			end
			clnw_pkg::OP_CLEAR: begin
				start.go     = req.valid && !busy;
				start.entry  = clnw_pkg::ENTRY_CLEAR;
				start.byte_v = clnw_pkg::CLEAR_CMD;
			end
			default: begin
				start.go = 1'b0;
			end
		endcase
	end

	clnw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.slot_free (slot_free),
		.busy      (busy),
		.issue     (issue),
		.word      (word)
	);

	clnw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.issue     (issue),
		.word      (word),
		.slot_free (slot_free),
		.step      (step)
	);

endmodule

// File: dv/clnw_checker.sv
`timescale 1ns / 100ps

module clnw_checker (
	input  logic  clk,
	input  logic  arst_n,
	clnw_req_if   req,
	clnw_step_if  step,
	output int    pending_steps,
	output int    error_count
);

	// Pin timing in delay units
	localparam logic [3:0] WAKE_NIB_FIRST = 4'd3;
	localparam logic [3:0] WAKE_NIB_LAST  = 4'd2;
	localparam logic [3:0] WAKE_HOLD      = 4'd10;
	localparam logic [3:0] WAKE_SETTLE    = 4'd0;
	localparam logic [3:0] HOLD_SHORT     = 4'd1;
	localparam logic [3:0] HOLD_LOW_NIB   = 4'd5;
	localparam logic [3:0] HOLD_CLEAR     = 4'd11;
	localparam int         WAKE_REPEATS   = 3;
	localparam int         MAX_REPORTS    = 10;

	typedef struct packed {
		logic [3:0] nibble;
		logic       reg_select;
		logic       enable;
		logic [3:0] hold_units;
		logic       last;
	} pin_step_t;

	pin_step_t expected_steps[$];

	initial begin
		error_count   = 0;
		pending_steps = 0;
	end

	task automatic push_step(input logic [3:0] nib, input logic rs, input logic en,
			input logic [3:0] hold, input logic fin);
		pin_step_t s;
		s.nibble     = nib;
		s.reg_select = rs;
		s.enable     = en;
		s.hold_units = hold;
		s.last       = fin;
		expected_steps.push_back(s);
	endtask

	// One byte: high nibble strobe, then low nibble strobe
	task automatic push_byte(input logic [7:0] b, input logic rs, input logic [3:0] first_hold,
			input logic [3:0] tail_hold, input logic fin);
		push_step(b[7:4], rs, 1'b1, first_hold, 1'b0);
		push_step(b[7:4], rs, 1'b0, HOLD_SHORT, 1'b0);
		push_step(b[3:0], rs, 1'b1, HOLD_LOW_NIB, 1'b0);
		push_step(b[3:0], rs, 1'b0, tail_hold, fin);
	endtask

	task automatic push_wake(input logic [3:0] nib);
		push_step(nib, 1'b0, 1'b1, WAKE_HOLD, 1'b0);
		push_step(nib, 1'b0, 1'b0, WAKE_SETTLE, 1'b0);
	endtask

	// Expected pin steps of one request; unused codes give none
	task automatic predict_request(input logic [2:0] op, input logic [7:0] bv,
			input logic row, input logic [7:0] col);
		logic [7:0] cursor_cmd;
		cursor_cmd = (row ? clnw_pkg::ROW1_BASE : clnw_pkg::ROW0_BASE) + {4'd0, col[3:0]};
		case (op)
			clnw_pkg::OP_INIT: begin
				for (int i = 0; i < WAKE_REPEATS; i++)
					push_wake(WAKE_NIB_FIRST);
				push_wake(WAKE_NIB_LAST);
				push_byte(clnw_pkg::INIT_CMD, 1'b0, HOLD_SHORT, HOLD_SHORT, 1'b0);
				push_byte(clnw_pkg::CLEAR_CMD, 1'b0, HOLD_SHORT, HOLD_CLEAR, 1'b1);
			end
			clnw_pkg::OP_CMD:    push_byte(bv, 1'b0, HOLD_SHORT, HOLD_SHORT, 1'b1);
			clnw_pkg::OP_DATA:   push_byte(bv, 1'b1, clnw_pkg::DATA_HOLD, HOLD_SHORT, 1'b1);
			clnw_pkg::OP_CURSOR: push_byte(cursor_cmd, 1'b0, HOLD_SHORT, HOLD_SHORT, 1'b1);
			clnw_pkg::OP_CLEAR:
				push_byte(clnw_pkg::CLEAR_CMD, 1'b0, HOLD_SHORT, HOLD_CLEAR, 1'b1);
			default: ;
		endcase
	endtask

	// Compare accepted pin steps, then queue the steps of an accepted request
	always @(posedge clk) begin : watch
		pin_step_t seen;
		pin_step_t want;
		if (arst_n) begin
			if (step.valid && step.ready) begin
				seen = '{step.nibble, step.reg_select, step.enable, step.hold_units, step.last};
				if (expected_steps.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: unexpected pin step nib %h rs %b en %b hold %0d last %b",
							$time, seen.nibble, seen.reg_select, seen.enable,
							seen.hold_units, seen.last);
				end else begin
					want = expected_steps.pop_front();
					if (seen.nibble !== want.nibble || seen.reg_select !== want.reg_select ||
							seen.enable !== want.enable || seen.hold_units !== want.hold_units ||
							seen.last !== want.last) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display({"%0t: pin step mismatch: expected nib %h rs %b en %b ",
								"hold %0d last %b, got nib %h rs %b en %b hold %0d last %b"},
								$time, want.nibble, want.reg_select, want.enable,
								want.hold_units, want.last, seen.nibble, seen.reg_select,
								seen.enable, seen.hold_units, seen.last);
					end
				end
			end
			if (req.valid && req.ready)
				predict_request(req.operation, req.byte_value, req.row, req.column);
		end
		pending_steps = expected_steps.size();
	end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_SLICE  = 140;
	localparam int LONG_HOLD     = 400;
	localparam int FLOOD_ITEMS   = 12;
	localparam int DRAIN_CYCLES  = 20;

	// Codes the block ignores
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_MID   = 3'd6;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	typedef enum logic [1:0] {
		RX_FREE   = 2'd0,
		RX_MOSTLY = 2'd1,
		RX_SPARSE = 2'd2,
		RX_TOGGLE = 2'd3
	} rx_mode_t;

	logic clk;
	logic arst_n;
	int   error_count;
	int   pending_steps;
	int   cycle_count;
	int   burst_left;
	bit   hold_off_request = 1'b0;

	clnw_req_if  req_ch ();
	clnw_step_if step_ch ();

	char_lcd_nibble_write_sequencer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.step   (step_ch)
	);

	clnw_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.step          (step_ch),
		.pending_steps (pending_steps),
		.error_count   (error_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Run guard
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Pin step receiver: stall pattern changes now and then, plus one long hold-off
	initial begin : receiver
		rx_mode_t mode;
		int       mode_left;
		step_ch.ready = 1'b0;
		mode          = RX_FREE;
		mode_left     = 0;
		forever begin
			@(negedge clk);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				step_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 120);
				end
				mode_left--;
				case (mode)
					RX_FREE:   step_ch.ready <= 1'b1;
					RX_MOSTLY: step_ch.ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE: step_ch.ready <= ($urandom_range(0, 9) < 3);
					RX_TOGGLE: step_ch.ready <= mode_left[1];
					default:   step_ch.ready <= 1'b1;
				endcase
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance
	task automatic send_request(input logic [2:0] op, input logic [7:0] bv,
			input logic r, input logic [7:0] col);
		req_ch.valid      <= 1'b1;
		req_ch.operation  <= op;
		req_ch.byte_value <= bv;
		req_ch.row        <= r;
		req_ch.column     <= col;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Random request, weighted toward printable traffic
	task automatic send_random(output bit counted);
		int         pick;
		logic [2:0] op;
		pick = $urandom_range(0, 99);
		if (pick < 10)
			op = clnw_pkg::OP_INIT;
		else if (pick < 30)
			op = clnw_pkg::OP_CMD;
		else if (pick < 60)
			op = clnw_pkg::OP_DATA;
		else if (pick < 80)
			op = clnw_pkg::OP_CURSOR;
		else if (pick < 93)
			op = clnw_pkg::OP_CLEAR;
		else
			op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		counted = (op <= clnw_pkg::OP_CLEAR);
		send_request(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
			8'($urandom_range(0, 255)));
	endtask

	// Sender bursts with random gaps in between
	task automatic pace();
		burst_left--;
		if (burst_left <= 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
		end
	endtask

	task automatic send_random_paced(input int count);
		int n;
		bit counted;
		n = 0;
		while (n < count) begin
			send_random(counted);
			if (counted)
				n++;
			pace();
		end
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		do @(negedge clk); while (pending_steps != 0);
	endtask

	initial begin : stimulus
		bit counted;
		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.operation  = '0;
		req_ch.byte_value = '0;
		req_ch.row        = 1'b0;
		req_ch.column     = '0;
		burst_left        = 1;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: every operation, field extremes, column wrap, ignored codes
		send_request(clnw_pkg::OP_INIT,   8'h00, 1'b0, 8'h00);
		send_request(clnw_pkg::OP_CMD,    8'h00, 1'b1, 8'hFF);
		send_request(clnw_pkg::OP_CMD,    8'hFF, 1'b0, 8'h00);
		send_request(clnw_pkg::OP_CMD,    8'h5A, 1'b1, 8'hA5);
		send_request(clnw_pkg::OP_DATA,   8'h00, 1'b1, 8'hFF);
		send_request(clnw_pkg::OP_DATA,   8'hFF, 1'b0, 8'h00);
		send_request(clnw_pkg::OP_DATA,   8'hA5, 1'b1, 8'h5A);
		send_request(clnw_pkg::OP_CURSOR, 8'hFF, 1'b0, 8'h00);
		send_request(clnw_pkg::OP_CURSOR, 8'h00, 1'b0, 8'h0F);
		send_request(clnw_pkg::OP_CURSOR, 8'h00, 1'b1, 8'h00);
		send_request(clnw_pkg::OP_CURSOR, 8'hFF, 1'b1, 8'hFF);
		send_request(clnw_pkg::OP_CURSOR, 8'h00, 1'b1, 8'h10);
		send_request(clnw_pkg::OP_CURSOR, 8'h00, 1'b0, 8'hAA);
		send_request(clnw_pkg::OP_CLEAR,  8'hFF, 1'b1, 8'hFF);
		send_request(OP_UNUSED_FIRST, 8'hFF, 1'b1, 8'hFF);
		send_request(OP_UNUSED_MID, 8'h00, 1'b0, 8'h00);
		send_request(OP_UNUSED_LAST, 8'h3C, 1'b1, 8'hC3);
		send_request(clnw_pkg::OP_CLEAR,  8'h00, 1'b0, 8'h00);
		send_request(clnw_pkg::OP_INIT,   8'hFF, 1'b1, 8'hFF);
		wait_drained();

		send_random_paced(RANDOM_SLICE);

		// Receiver holds off while requests keep coming, so the block backs up
		hold_off_request = 1'b1;
		repeat (FLOOD_ITEMS) send_random(counted);
		burst_left = 1;
		pace();

		send_random_paced(RANDOM_SLICE);
		wait_drained();
		send_random_paced(RANDOM_SLICE);

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
